/* design/kvt_pkg.sv */
// Shared types and constants for the keyed value table.
package kvt_pkg;

    localparam int DEFAULT_DEPTH = 32;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int RESULT_CNT_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_ERASE_ALL = 3'd1,
        CMD_ERASE_ONE = 3'd2,
        CMD_CONTAINS  = 3'd3,
        CMD_COUNT     = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_DUP     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_key;
    } req_item_t;

    typedef struct packed {
        status_t                 status;
        logic                    found;
        logic [RESULT_CNT_W-1:0] tally;
        logic [RESULT_CNT_W-1:0] occupancy;
    } rsp_item_t;

    // Command held steady for the whole walk down the chain.
    typedef struct packed {
        cmd_t                     cmd;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] key;
        logic                     ins_en;
    } query_t;

    // Flags carried by the token from cell to cell.
    typedef struct packed {
        logic active;
        logic found;
        logic dup;
        logic placed;
    } token_t;

    // Resolves a tentative insert once the whole chain has been checked.
    typedef struct packed {
        logic strobe;
        logic keep;
    } commit_t;

endpackage

/* design/kvt_cell.sv */
// One table slot: holds an entry and processes the token as it passes by.
module kvt_cell #(
    parameter int CNT_W = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kvt_pkg::query_t       query,
    input  kvt_pkg::commit_t      commit,
    input  kvt_pkg::token_t       tok_in,
    input  logic [CNT_W-1:0]      tally_in,
    output kvt_pkg::token_t       tok_out,
    output logic [CNT_W-1:0]      tally_out
);

    logic                             valid_reg, valid_next;
    logic                             pend_reg, pend_next;
    logic signed [kvt_pkg::DATA_W-1:0] value_reg, value_next;
    logic signed [kvt_pkg::DATA_W-1:0] key_reg, key_next;
    kvt_pkg::token_t                  tok_reg, tok_next;
    logic [CNT_W-1:0]                 tally_reg, tally_next;
    logic                             hit_value;
    logic                             hit_key;

    assign hit_value = valid_reg && (value_reg == query.value);
    assign hit_key   = valid_reg && (key_reg == query.key);

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        value_next = value_reg;
        key_next   = key_reg;
        tok_next   = tok_in;
        tally_next = tally_in;

        // A slot claimed by an insert becomes live only if no duplicate turned up.
        if (commit.strobe && pend_reg)
        begin
            valid_next = commit.keep;
            pend_next  = 1'b0;
        end

        if (tok_in.active)
        begin
            unique case (query.cmd)
                kvt_pkg::CMD_INSERT:
                begin
                    if (hit_key)
                        tok_next.dup = 1'b1;
                    if (query.ins_en && !valid_reg && !tok_in.placed)
                    begin
                        value_next      = query.value;
                        key_next        = query.key;
                        pend_next       = 1'b1;
                        tok_next.placed = 1'b1;
                    end
                end
                kvt_pkg::CMD_ERASE_ALL:
                begin
                    if (hit_value)
                    begin
                        valid_next = 1'b0;
                        tally_next = tally_in + CNT_W'(1);
                    end
                end
                kvt_pkg::CMD_ERASE_ONE:
                begin
                    if (hit_key)
                    begin
                        valid_next     = 1'b0;
                        tok_next.found = 1'b1;
                    end
                end
                kvt_pkg::CMD_CONTAINS:
                begin
                    if (hit_key)
                        tok_next.found = 1'b1;
                end
                kvt_pkg::CMD_COUNT:
                begin
                    if (hit_value)
                        tally_next = tally_in + CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        key_reg   <= key_next;
        tally_reg <= tally_next;
    end

    assign tok_out   = tok_reg;
    assign tally_out = tally_reg;

endmodule

/* design/keyed_value_table_core.sv */
// Top level of the keyed value table: request control, cell chain and result stage.
//
//   channel | signals                   | direction | carries
//   --------+---------------------------+-----------+-------------------------------
//   req     | req_valid req_ready req   | in        | command, item_value, item_key
//   rsp     | rsp_valid rsp_ready rsp   | out       | status, found, tally, occupancy
//
// Each item walks a token through TABLE_DEPTH cells, one cell per cycle, and the
// result passes from the last cell into a holding register; req stays low while
// the scan runs, so a new item is accepted only after the previous one finished.
// Reset clears the entry count and the per-slot valid bits at once; no sweep.
// A finished result moves from the holding register into the output register;
// while rsp is stalled one more result waits behind it and holds req off.
module keyed_value_table_core #(
    parameter int TABLE_DEPTH = kvt_pkg::DEFAULT_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  kvt_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output kvt_pkg::rsp_item_t rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int RW    = kvt_pkg::RESULT_CNT_W;

    kvt_pkg::state_t    state_reg, state_next;
    kvt_pkg::query_t    query_reg, query_next;
    logic               inj_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    kvt_pkg::rsp_item_t res_reg, res_next;
    logic               res_pend_reg;
    kvt_pkg::rsp_item_t out_reg;
    logic               out_valid_reg;

    kvt_pkg::token_t    tok [0:TABLE_DEPTH];
    logic [CNT_W-1:0]   tal [0:TABLE_DEPTH];
    kvt_pkg::commit_t   commit;

    logic               accept;
    logic               scan_done;
    kvt_pkg::token_t    tok_end;
    logic [CNT_W-1:0]   tally_end;
    logic               keep;
    logic [CNT_W+RW-1:0] tally_wide;
    logic [CNT_W+RW-1:0] occ_wide;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign accept    = req_valid && req_ready;
    assign tok_end   = tok[TABLE_DEPTH];
    assign tally_end = tal[TABLE_DEPTH];
    assign scan_done = tok_end.active;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kvt_pkg::ST_IDLE:
                if (accept)
                    state_next = kvt_pkg::ST_SCAN;
            kvt_pkg::ST_SCAN:
                if (scan_done)
                    state_next = kvt_pkg::ST_IDLE;
            default:
                state_next = kvt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        unique case (state_reg)
            kvt_pkg::ST_IDLE: req_ready = !res_pend_reg;
            kvt_pkg::ST_SCAN: req_ready = 1'b0;
            default:          req_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        query_next = query_reg;
        if (accept)
        begin
            query_next.cmd    = kvt_pkg::cmd_t'(req.command);
            query_next.value  = req.item_value;
            query_next.key    = req.item_key;
            query_next.ins_en = count_reg < CNT_W'(TABLE_DEPTH);
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    assign tok[0] = '{active: inj_reg, found: 1'b0, dup: 1'b0, placed: 1'b0};
    assign tal[0] = '0;

    assign keep          = (query_reg.cmd == kvt_pkg::CMD_INSERT) && query_reg.ins_en
                           && tok_end.placed && !tok_end.dup;
    assign commit        = '{strobe: scan_done, keep: keep};

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        kvt_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .query     (query_reg),
            .commit    (commit),
            .tok_in    (tok[g]),
            .tally_in  (tal[g]),
            .tok_out   (tok[g+1]),
            .tally_out (tal[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next       = count_reg;
        res_next.status  = kvt_pkg::STATUS_OK;
        res_next.found   = 1'b0;
        res_next.tally   = '0;
        tally_wide       = {{RW{1'b0}}, tally_end};

        unique case (query_reg.cmd)
            kvt_pkg::CMD_INSERT:
            begin
                if (!query_reg.ins_en)
                    res_next.status = kvt_pkg::STATUS_FULL;
                else if (tok_end.dup)
                    res_next.status = kvt_pkg::STATUS_DUP;
                count_next = count_reg + CNT_W'(keep);
            end
            kvt_pkg::CMD_ERASE_ALL:
            begin
                res_next.tally = tally_wide[RW-1:0];
                count_next     = count_reg - tally_end;
            end
            kvt_pkg::CMD_ERASE_ONE:
            begin
                res_next.found = tok_end.found;
                if (!tok_end.found)
                    res_next.status = kvt_pkg::STATUS_MISSING;
                count_next = count_reg - CNT_W'(tok_end.found);
            end
            kvt_pkg::CMD_CONTAINS:
                res_next.found = tok_end.found;
            kvt_pkg::CMD_COUNT:
                res_next.tally = tally_wide[RW-1:0];
            default:
            begin
            end
        endcase

        occ_wide           = {{RW{1'b0}}, count_next};
        res_next.occupancy = occ_wide[RW-1:0];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvt_pkg::ST_IDLE;
            inj_reg       <= 1'b0;
            count_reg     <= '0;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            inj_reg   <= accept;
            if (scan_done)
            begin
                count_reg    <= count_next;
                res_pend_reg <= 1'b1;
            end
            else if (res_pend_reg && (!out_valid_reg || rsp_ready))
                res_pend_reg <= 1'b0;

            if (res_pend_reg && (!out_valid_reg || rsp_ready))
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
        if (scan_done)
            res_reg <= res_next;
        if (res_pend_reg && (!out_valid_reg || rsp_ready))
            out_reg <= res_reg;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
